[rtl/tbp_pkg.sv]
// Shared widths, payload types and status codes of the barycentric projection unit.
package tbp_pkg;

    // Input coordinate format
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int N_COORDS    = 12;

    // Weight format: fraction bits and the internal hold level (a power of two)
    localparam int WEIGHT_FRAC = 16;
    localparam int CLAMP_LOG   = 20;
    localparam int Q_W         = CLAMP_LOG + 1;
    localparam int OUT_W       = 20;
    localparam int STATUS_W    = 2;
    localparam int LIMIT_W     = 32;

    // Internal widths, each sized for the exact worst case of its value
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int LIMB_W    = (CROSS_W + 1) / 2;
    localparam int HI_W      = CROSS_W - LIMB_W;
    localparam int DOT_W     = 2 * CROSS_W;
    localparam int WN_W      = DIFF_W + CROSS_W + 2;
    localparam int NUMA_W    = DOT_W + 2;
    localparam int WN_LIMBS  = (WN_W + LIMB_W - 1) / LIMB_W;
    localparam int DEN_LIMBS = (DOT_W + LIMB_W - 1) / LIMB_W;
    localparam int SQ_W      = 2 * WN_LIMBS * LIMB_W;
    localparam int LD_W      = LIMIT_W + DEN_LIMBS * LIMB_W;
    localparam int RES_W     = SQ_W + 2 * FRAC_BITS + WEIGHT_FRAC;
    localparam int D_W       = DOT_W + 1;
    localparam int DIV_W     = DOT_W + Q_W + 1;

    // Stream bus widths, padded to whole bytes
    localparam int IN_DATA_W  = ((N_COORDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(6554);
    localparam logic [Q_W-1:0]     WEIGHT_CLAMP = Q_W'(2 ** CLAMP_LOG);
    localparam logic [Q_W-1:0]     WEIGHT_ONE   = Q_W'(2 ** WEIGHT_FRAC);

    typedef enum logic [STATUS_W-1:0] {
        ST_INSIDE     = 2'd0,
        ST_OFF_PLANE  = 2'd1,
        ST_OUTSIDE    = 2'd2,
        ST_DEGENERATE = 2'd3
    } status_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [CROSS_W-1:0]     cross_t;
    typedef logic signed [DOT_W-1:0]       dot_t;
    typedef logic signed [WN_W-1:0]        wn_t;
    typedef logic signed [NUMA_W-1:0]      numa_t;
    typedef logic [DIV_W-1:0]              div_t;
    typedef logic [D_W-1:0]                den2_t;
    typedef logic [Q_W-1:0]                quot_t;
    typedef logic signed [OUT_W-1:0]       weight_t;

    // Products of the geometry section
    typedef struct packed {
        dot_t den;
        dot_t num_b;
        dot_t num_g;
        wn_t  wn;
    } geo_t;

    // Flags that ride alongside the division
    typedef struct packed {
        logic       degen;
        logic       off;
        logic [2:0] neg;
        logic [2:0] clamp;
    } side_t;

    typedef struct packed {
        div_t [2:0] rem;
        den2_t      d;
        side_t      side;
    } div_in_t;

    typedef struct packed {
        quot_t [2:0] q;
        side_t       side;
    } div_out_t;

endpackage

[rtl/tbp_geometry.sv]
// Edge vectors, normal, cross products and dot products: six register stages.
module tbp_geometry (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  tbp_pkg::coord_t coords [12],
    output logic            out_valid,
    output tbp_pkg::geo_t   geo
);
    import tbp_pkg::*;

    localparam int STAGES = 6;
    localparam int HH_W   = 2 * HI_W;
    localparam int HL_W   = HI_W + LIMB_W + 1;
    localparam int LL_W   = 2 * LIMB_W;
    localparam int WH_W   = DIFF_W + HI_W;
    localparam int WL_W   = DIFF_W + LIMB_W + 1;
    localparam int NX [3] = '{1, 2, 0};
    localparam int NY [3] = '{2, 0, 1};

    logic [STAGES-1:0] valid_reg;

    diff_t  u_reg [3];
    diff_t  v_reg [3];
    diff_t  w_reg [3];
    prod_t  pa_reg [3][3];
    prod_t  pb_reg [3][3];
    diff_t  w2_reg [3];
    cross_t cr_reg [3][3];
    diff_t  w3_reg [3];
    logic signed [HH_W-1:0] hh_reg [3][3];
    logic signed [HL_W-1:0] hl_reg [3][3];
    logic signed [HL_W-1:0] lh_reg [3][3];
    logic        [LL_W-1:0] ll_reg [3][3];
    logic signed [WH_W-1:0] wh_reg [3];
    logic signed [WL_W-1:0] wl_reg [3];
    dot_t   pr_reg [3][3];
    wn_t    wp_reg [3];
    geo_t   geo_reg;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // stage 1: u = V1-V0, v = V2-V0, w = P-V0
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= diff_t'(coords[6 + k]) - diff_t'(coords[3 + k]);
                v_reg[k] <= diff_t'(coords[9 + k]) - diff_t'(coords[3 + k]);
                w_reg[k] <= diff_t'(coords[k]) - diff_t'(coords[3 + k]);
            end
        end
    end

    // stage 2: cross product terms of u x v, u x w and w x v
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pa_reg[0][k] <= u_reg[NX[k]] * v_reg[NY[k]];
                pb_reg[0][k] <= u_reg[NY[k]] * v_reg[NX[k]];
                pa_reg[1][k] <= u_reg[NX[k]] * w_reg[NY[k]];
                pb_reg[1][k] <= u_reg[NY[k]] * w_reg[NX[k]];
                pa_reg[2][k] <= w_reg[NX[k]] * v_reg[NY[k]];
                pb_reg[2][k] <= w_reg[NY[k]] * v_reg[NX[k]];
                w2_reg[k]    <= w_reg[k];
            end
        end
    end

    // stage 3: cross products (index 0 is the normal)
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    cr_reg[c][k] <= cross_t'(pa_reg[c][k]) - cross_t'(pb_reg[c][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                w3_reg[k] <= w2_reg[k];
            end
        end
    end

    // stage 4: partial products, operands split into a signed high and unsigned low half
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < 3; d++) begin
                for (int k = 0; k < 3; k++) begin
                    hh_reg[d][k] <= $signed(cr_reg[d][k][CROSS_W-1:LIMB_W])
                                  * $signed(cr_reg[0][k][CROSS_W-1:LIMB_W]);
                    hl_reg[d][k] <= $signed(cr_reg[d][k][CROSS_W-1:LIMB_W])
                                  * $signed({1'b0, cr_reg[0][k][LIMB_W-1:0]});
                    lh_reg[d][k] <= $signed({1'b0, cr_reg[d][k][LIMB_W-1:0]})
                                  * $signed(cr_reg[0][k][CROSS_W-1:LIMB_W]);
                    ll_reg[d][k] <= cr_reg[d][k][LIMB_W-1:0] * cr_reg[0][k][LIMB_W-1:0];
                end
            end
            for (int k = 0; k < 3; k++) begin
                wh_reg[k] <= w3_reg[k] * $signed(cr_reg[0][k][CROSS_W-1:LIMB_W]);
                wl_reg[k] <= w3_reg[k] * $signed({1'b0, cr_reg[0][k][LIMB_W-1:0]});
            end
        end
    end

    // stage 5: assemble each full product
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < 3; d++) begin
                for (int k = 0; k < 3; k++) begin
                    pr_reg[d][k] <= (dot_t'(hh_reg[d][k]) <<< (2 * LIMB_W))
                                  + (dot_t'(hl_reg[d][k]) <<< LIMB_W)
                                  + (dot_t'(lh_reg[d][k]) <<< LIMB_W)
                                  + dot_t'(ll_reg[d][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                wp_reg[k] <= (wn_t'(wh_reg[k]) <<< LIMB_W) + wn_t'(wl_reg[k]);
            end
        end
    end

    // stage 6: n.n, (u x w).n, (w x v).n and w.n
    always_ff @(posedge aclk) begin
        if (en) begin
            geo_reg.den   <= pr_reg[0][0] + pr_reg[0][1] + pr_reg[0][2];
            geo_reg.num_g <= pr_reg[1][0] + pr_reg[1][1] + pr_reg[1][2];
            geo_reg.num_b <= pr_reg[2][0] + pr_reg[2][1] + pr_reg[2][2];
            geo_reg.wn    <= wp_reg[0] + wp_reg[1] + wp_reg[2];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign geo       = geo_reg;

endmodule

[rtl/tbp_residual.sv]
// Plane residual test and dividend set-up for the weight division: three register stages.
module tbp_residual (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  tbp_pkg::geo_t                geo,
    input  logic [tbp_pkg::LIMIT_W-1:0]  limit,
    output logic                         out_valid,
    output tbp_pkg::div_in_t             dv
);
    import tbp_pkg::*;

    localparam int STAGES  = 3;
    localparam int SQP_W   = 2 * LIMB_W;
    localparam int LDP_W   = LIMIT_W + LIMB_W;
    localparam int WN_EXT  = WN_LIMBS * LIMB_W;
    localparam int DEN_EXT = DEN_LIMBS * LIMB_W;

    logic [STAGES-1:0] valid_reg;

    logic [WN_W-1:0]    wn_mag;
    logic [WN_EXT-1:0]  wn_ext;
    logic [DEN_EXT-1:0] den_ext;
    numa_t              num_next [3];

    logic [SQP_W-1:0]   sq_pp_reg [WN_LIMBS][WN_LIMBS];
    logic [LDP_W-1:0]   ld_pp_reg [DEN_LIMBS];
    numa_t              num7_reg [3];
    logic [DOT_W-1:0]   den7_reg;

    logic [SQ_W-1:0]    sq_next;
    logic [LD_W-1:0]    ld_next;
    logic [NUMA_W-1:0]  mag [3];
    div_t               n_next [3];

    logic [SQ_W-1:0]    sq8_reg;
    logic [LD_W-1:0]    ld8_reg;
    div_t               n8_reg [3];
    den2_t              d8_reg;
    logic [2:0]         neg8_reg;
    logic               degen8_reg;

    div_in_t            dv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // alpha numerator and magnitudes for the limb products
    always_comb begin
        wn_mag      = geo.wn[WN_W-1] ? WN_W'(-$signed(geo.wn)) : WN_W'(geo.wn);
        wn_ext      = WN_EXT'(wn_mag);
        den_ext     = DEN_EXT'($unsigned(geo.den));
        num_next[0] = numa_t'($signed(geo.den)) - numa_t'($signed(geo.num_b))
                    - numa_t'($signed(geo.num_g));
        num_next[1] = numa_t'($signed(geo.num_b));
        num_next[2] = numa_t'($signed(geo.num_g));
    end

    // stage 1: limb products of (w.n)^2 and limit * n.n
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < WN_LIMBS; i++) begin
                for (int j = 0; j < WN_LIMBS; j++) begin
                    sq_pp_reg[i][j] <= wn_ext[i*LIMB_W +: LIMB_W] * wn_ext[j*LIMB_W +: LIMB_W];
                end
            end
            for (int i = 0; i < DEN_LIMBS; i++) begin
                ld_pp_reg[i] <= limit * den_ext[i*LIMB_W +: LIMB_W];
            end
            for (int l = 0; l < 3; l++) begin
                num7_reg[l] <= num_next[l];
            end
            den7_reg <= geo.den;
        end
    end

    // limb sums and dividends |num| * 2^17 + n.n
    always_comb begin
        sq_next = '0;
        for (int i = 0; i < WN_LIMBS; i++) begin
            for (int j = 0; j < WN_LIMBS; j++) begin
                sq_next = sq_next + (SQ_W'(sq_pp_reg[i][j]) << (LIMB_W * (i + j)));
            end
        end
        ld_next = '0;
        for (int i = 0; i < DEN_LIMBS; i++) begin
            ld_next = ld_next + (LD_W'(ld_pp_reg[i]) << (LIMB_W * i));
        end
        for (int l = 0; l < 3; l++) begin
            mag[l]    = num7_reg[l][NUMA_W-1] ? NUMA_W'(-num7_reg[l]) : NUMA_W'(num7_reg[l]);
            n_next[l] = (DIV_W'(mag[l]) << (WEIGHT_FRAC + 1)) + DIV_W'(den7_reg);
        end
    end

    // stage 2
    always_ff @(posedge aclk) begin
        if (en) begin
            sq8_reg    <= sq_next;
            ld8_reg    <= ld_next;
            d8_reg     <= den2_t'(den7_reg) << 1;
            degen8_reg <= (den7_reg == '0);
            for (int l = 0; l < 3; l++) begin
                n8_reg[l]   <= n_next[l];
                neg8_reg[l] <= num7_reg[l][NUMA_W-1];
            end
        end
    end

    // stage 3: residual compare and out-of-range detection before the divider
    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg.d          <= d8_reg;
            dv_reg.side.degen <= degen8_reg;
            dv_reg.side.neg   <= neg8_reg;
            dv_reg.side.off   <= (RES_W'(sq8_reg) << WEIGHT_FRAC)
                               > (RES_W'(ld8_reg) << (2 * FRAC_BITS));
            for (int l = 0; l < 3; l++) begin
                dv_reg.rem[l]        <= n8_reg[l];
                dv_reg.side.clamp[l] <= n8_reg[l] >= (DIV_W'(d8_reg) << Q_W);
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign dv        = dv_reg;

endmodule

[rtl/tbp_divider.sv]
// Three-lane restoring divider, one quotient bit per register stage.
module tbp_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  tbp_pkg::div_in_t   din,
    output logic               out_valid,
    output tbp_pkg::div_out_t  dout
);
    import tbp_pkg::*;

    logic [Q_W-1:0] valid_reg;
    div_t  rem_reg  [Q_W][3];
    quot_t q_reg    [Q_W][3];
    den2_t d_reg    [Q_W];
    side_t side_reg [Q_W];

    div_t  src_rem  [Q_W][3];
    quot_t src_q    [Q_W][3];
    den2_t src_d    [Q_W];
    div_t  sub_val  [Q_W];
    div_t  rem_next [Q_W][3];
    quot_t q_next   [Q_W][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    // stage s decides quotient bit Q_W-1-s
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            src_rem[0][l] = din.rem[l];
            src_q[0][l]   = '0;
        end
        src_d[0] = din.d;
        for (int s = 1; s < Q_W; s++) begin
            for (int l = 0; l < 3; l++) begin
                src_rem[s][l] = rem_reg[s-1][l];
                src_q[s][l]   = q_reg[s-1][l];
            end
            src_d[s] = d_reg[s-1];
        end
        for (int s = 0; s < Q_W; s++) begin
            sub_val[s] = DIV_W'(src_d[s]) << (Q_W - 1 - s);
            for (int l = 0; l < 3; l++) begin
                if (src_rem[s][l] >= sub_val[s]) begin
                    rem_next[s][l] = src_rem[s][l] - sub_val[s];
                    q_next[s][l]   = src_q[s][l] | (Q_W'(1) << (Q_W - 1 - s));
                end else begin
                    rem_next[s][l] = src_rem[s][l];
                    q_next[s][l]   = src_q[s][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < Q_W; s++) begin
                for (int l = 0; l < 3; l++) begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
                d_reg[s] <= src_d[s];
            end
            side_reg[0] <= din.side;
            for (int s = 1; s < Q_W; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            dout.q[l] = q_reg[Q_W-1][l];
        end
        dout.side = side_reg[Q_W-1];
    end

    assign out_valid = valid_reg[Q_W-1];

endmodule

[rtl/triangle_barycentric_projection_unit.sv]
// Top level of the barycentric projection unit: pipeline, classification and output stage.
//
// Usage:
//   s_ channel: one beat per query, a point and three triangle vertices in
//   signed Q8.16. m_ channel: one beat per query with the three barycentric
//   weights (signed Q3.16, saturated) in m_tdata and the status in m_tuser
//   (inside, off plane, outside, degenerate triangle).
//   cfg_we/cfg_wdata write the squared residual limit (unsigned, 16
//   fraction bits) while no query is in flight.
// Pipeline: 6 geometry stages, 3 residual/dividend stages, 21 divider
//   stages (one quotient bit each) and the output register.
// Throughput: one beat per cycle while s_tready is high; the divider is fully pipelined.
// Reset: aresetn (synchronous, active low) empties the pipeline and the
//   output stage and sets the limit to 6554.
// Stall: while m_tready is low the result sits in the output register and
//   one more beat is caught in a skid register; only then does s_tready
//   drop and the whole pipeline hold, losing nothing.
module triangle_barycentric_projection_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, point_z, vert0_x/y/z, vert1_x/y/z, vert2_x/y/z
    input  logic [tbp_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // weight_a, weight_b, weight_c, zero padding
    output logic [tbp_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status
    output logic [tbp_pkg::STATUS_W-1:0]     m_tuser,
    input  logic                             cfg_we,
    input  logic [tbp_pkg::LIMIT_W-1:0]      cfg_wdata
);
    import tbp_pkg::*;

    typedef struct packed {
        weight_t [2:0] w;
        status_t       status;
    } res_t;

    localparam logic signed [Q_W:0] W_MAX = (Q_W+1)'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [Q_W:0] W_MIN = -(Q_W+1)'(2 ** (OUT_W - 1));

    logic [LIMIT_W-1:0] limit_reg;
    logic               pipe_en;
    coord_t             coords [12];

    logic      geo_valid;
    geo_t      geo;
    logic      dv_valid;
    div_in_t   dv;
    logic      div_valid;
    div_out_t  dout;

    quot_t              qc [3];
    logic signed [Q_W:0] ws [3];
    logic               all_in;
    res_t               res_next;

    logic m_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;

    // limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // pipeline advances unless the skid register is holding a beat
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    always_comb begin
        for (int i = 0; i < N_COORDS; i++) begin
            coords[i] = coord_t'(s_tdata[i*COORD_WIDTH +: COORD_WIDTH]);
        end
    end

    tbp_geometry u_geometry (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .coords    (coords),
        .out_valid (geo_valid),
        .geo       (geo)
    );

    tbp_residual u_residual (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (geo_valid),
        .geo       (geo),
        .limit     (limit_reg),
        .out_valid (dv_valid),
        .dv        (dv)
    );

    tbp_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (dv_valid),
        .din       (dv),
        .out_valid (div_valid),
        .dout      (dout)
    );

    // weight hold, sign, saturation and classification
    always_comb begin
        all_in = 1'b1;
        for (int l = 0; l < 3; l++) begin
            qc[l] = (dout.side.clamp[l] || (dout.q[l] > WEIGHT_CLAMP)) ? WEIGHT_CLAMP
                                                                         : dout.q[l];
            ws[l] = $signed({1'b0, qc[l]});
            if (dout.side.neg[l]) begin
                ws[l] = -ws[l];
            end
            if (!((qc[l] == '0) || (!dout.side.neg[l] && (qc[l] <= WEIGHT_ONE)))) begin
                all_in = 1'b0;
            end
            if (ws[l] > W_MAX) begin
                res_next.w[l] = OUT_W'(W_MAX);
            end else if (ws[l] < W_MIN) begin
                res_next.w[l] = OUT_W'(W_MIN);
            end else begin
                res_next.w[l] = OUT_W'(ws[l]);
            end
        end
        priority if (dout.side.degen) begin
            res_next.status = ST_DEGENERATE;
            res_next.w      = '0;
        end else if (dout.side.off) begin
            res_next.status = ST_OFF_PLANE;
        end else if (all_in) begin
            res_next.status = ST_INSIDE;
        end else begin
            res_next.status = ST_OUTSIDE;
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (div_valid) begin
                if (!m_valid_reg || m_tready) begin
                    out_data_reg <= res_next;
                    m_valid_reg  <= 1'b1;
                end else begin
                    skid_data_reg  <= res_next;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg.w);
    assign m_tuser  = out_data_reg.status;

endmodule
